// ----- rtl/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg: shared types and codes for the wire field scanner
// Event, error and wire type codes, and the result record passed from the
// decode core to the output register.
// ----------------------------------------------------------------------------
package pws_pkg;

  // event codes
  localparam logic [1:0] EV_VARINT  = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;
  localparam logic [1:0] EV_HEADER  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_PAST_END  = 3'd3;
  localparam logic [2:0] ERR_GROUP     = 3'd4;
  localparam logic [2:0] ERR_WIRE      = 3'd5;

  // wire types
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_SGROUP  = 3'd3;
  localparam logic [2:0] WIRE_EGROUP  = 3'd4;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  // varint and fixed field sizes
  localparam logic [3:0]  VARINT_MAX_BYTES = 4'd10;
  localparam logic [6:0]  VARINT_GROUP     = 7'd7;
  localparam logic [63:0] FIXED64_LEN      = 64'd8;
  localparam logic [63:0] FIXED32_LEN      = 64'd4;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] varint_value;
    logic [7:0]  payload_byte;
    logic        field_end;
    logic [2:0]  error_code;
    logic        buffer_end;
  } result_t;

endpackage

// ----- rtl/pws_core.sv -----
// ----------------------------------------------------------------------------
// pws_core: per-byte decode and scanner state
// Holds the parse phase, the varint accumulator, the remaining byte count and
// the current tag. Each fired byte updates the state and may give one result.
// ----------------------------------------------------------------------------
module pws_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data,
  input  logic              last,
  output logic              res_valid,
  output pws_pkg::result_t  res
);
  import pws_pkg::*;

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_HOLD    = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] cur_field, cur_field_next;
  logic [2:0]  cur_wire, cur_wire_next;

  logic [6:0]  shamt;
  logic [63:0] acc_fed;
  logic [3:0]  cnt_fed;
  logic [63:0] rem_dec;
  logic        err_valid;
  logic [2:0]  err_code;

  // varint feed: seven bits per byte, low group first
  always_comb begin
    shamt = 7'(cnt) * VARINT_GROUP;
    if (cnt < VARINT_MAX_BYTES) begin
      acc_fed = acc | (64'(data[6:0]) << shamt);
      cnt_fed = cnt + 4'd1;
    end else begin
      acc_fed = acc;
      cnt_fed = cnt;
    end
    rem_dec = (remaining != 64'd0) ? remaining - 64'd1 : 64'd0;
  end

  // next state and result
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    remaining_next = remaining;
    cur_field_next = cur_field;
    cur_wire_next  = cur_wire;
    err_valid      = 1'b0;
    err_code       = ERR_NONE;
    res_valid      = 1'b0;
    res            = '0;

    if (phase inside {PH_TAG, PH_VALUE, PH_LENGTH}) begin
      if (phase == PH_TAG && cnt == 4'd0) begin
        cur_field_next = '0;
        cur_wire_next  = '0;
      end
      if (data[7] && cnt_fed >= VARINT_MAX_BYTES) begin
        err_valid = 1'b1;
        err_code  = ERR_TOO_LONG;
      end else if (data[7]) begin
        acc_next = acc_fed;
        cnt_next = cnt_fed;
        if (last) begin
          err_valid = 1'b1;
          err_code  = ERR_TRUNCATED;
        end
      end else begin
        acc_next = '0;
        cnt_next = '0;
        case (phase)
          PH_TAG: begin
            cur_field_next = acc_fed[34:3];
            cur_wire_next  = acc_fed[2:0];
            case (acc_fed[2:0])
              WIRE_VARINT, WIRE_LEN: begin
                if (last) begin
                  err_valid = 1'b1;
                  err_code  = ERR_TRUNCATED;
                end else begin
                  phase_next = (acc_fed[2:0] == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                end
              end
              WIRE_FIXED64, WIRE_FIXED32: begin
                if (last) begin
                  err_valid = 1'b1;
                  err_code  = ERR_PAST_END;
                end else begin
                  remaining_next = (acc_fed[2:0] == WIRE_FIXED64) ? FIXED64_LEN
                                                                  : FIXED32_LEN;
                  phase_next     = PH_PAYLOAD;
                end
              end
              WIRE_SGROUP, WIRE_EGROUP: begin
                err_valid = 1'b1;
                err_code  = ERR_GROUP;
              end
              default: begin
                err_valid = 1'b1;
                err_code  = ERR_WIRE;
              end
            endcase
          end
          PH_VALUE: begin
            res_valid          = 1'b1;
            res.event_res      = EV_VARINT;
            res.varint_value   = acc_fed;
            res.field_end      = 1'b1;
            phase_next         = PH_TAG;
          end
          default: begin
            // length varint
            if (acc_fed == 64'd0) begin
              res_valid      = 1'b1;
              res.event_res  = EV_HEADER;
              res.field_end  = 1'b1;
              phase_next     = PH_TAG;
            end else if (last) begin
              err_valid = 1'b1;
              err_code  = ERR_PAST_END;
            end else begin
              res_valid        = 1'b1;
              res.event_res    = EV_HEADER;
              res.varint_value = acc_fed;
              remaining_next   = acc_fed;
              phase_next       = PH_PAYLOAD;
            end
          end
        endcase
      end
    end else if (phase == PH_PAYLOAD) begin
      remaining_next = rem_dec;
      if (rem_dec == 64'd0) begin
        res_valid        = 1'b1;
        res.event_res    = EV_PAYLOAD;
        res.payload_byte = data;
        res.field_end    = 1'b1;
        phase_next       = PH_TAG;
      end else if (last) begin
        err_valid = 1'b1;
        err_code  = ERR_PAST_END;
      end else begin
        res_valid        = 1'b1;
        res.event_res    = EV_PAYLOAD;
        res.payload_byte = data;
      end
    end

    // error: report once, then hold until the end of the buffer
    if (err_valid) begin
      res_valid      = 1'b1;
      res            = '0;
      res.event_res  = EV_ERROR;
      res.error_code = err_code;
      phase_next     = PH_HOLD;
    end
    res.field_id   = cur_field_next;
    res.wire_kind  = cur_wire_next;
    res.buffer_end = last;

    // end of buffer returns everything to reset
    if (last) begin
      phase_next     = PH_TAG;
      acc_next       = '0;
      cnt_next       = '0;
      remaining_next = '0;
      cur_field_next = '0;
      cur_wire_next  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      acc       <= '0;
      cnt       <= '0;
      remaining <= '0;
      cur_field <= '0;
      cur_wire  <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      remaining <= remaining_next;
      cur_field <= cur_field_next;
      cur_wire  <= cur_wire_next;
    end
  end

endmodule

// ----- rtl/protobuf_wire_field_scanner.sv -----
// ----------------------------------------------------------------------------
// protobuf_wire_field_scanner: streaming wire-format field scanner
// A byte taken into the input register is decoded combinationally and its
// result is registered in the result register, which drives the output
// ports. Throughput: one byte per cycle while the output is not stalled.
// Reset: synchronous, clears the parse state and both register valids.
// ----------------------------------------------------------------------------
module protobuf_wire_field_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [31:0] field_id,
  output logic [2:0]  wire_kind,
  output logic [63:0] varint_value,
  output logic [7:0]  payload_byte,
  output logic        field_end,
  output logic [2:0]  error_code,
  output logic        buffer_end
);
  import pws_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_data;
  logic       in_q_last;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_q;

  // a byte is decoded when the result slot is free or being drained
  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_data <= data_byte;
      in_q_last <= last_byte;
    end
  end

  pws_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data      (in_q_data),
    .last      (in_q_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign event_res    = out_q.event_res;
  assign field_id     = out_q.field_id;
  assign wire_kind    = out_q.wire_kind;
  assign varint_value = out_q.varint_value;
  assign payload_byte = out_q.payload_byte;
  assign field_end    = out_q.field_end;
  assign error_code   = out_q.error_code;
  assign buffer_end   = out_q.buffer_end;

`ifndef ASSERT_OFF
  // a stalled result is never overwritten by a new decode
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(fire && out_valid && out_stall))
    else $error("result overwritten while stalled");

  // error events carry a code, other events carry none
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_res == EV_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match event");

  // a varint field always completes its field
  a_varint_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_VARINT) |-> field_end)
    else $error("varint event without field end");

  // errors never complete a field
  a_error_no_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_ERROR) |-> !field_end)
    else $error("error event marked as field end");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the protobuf wire field scanner
// A short table of hand-written byte streams comes first, then random
// messages, mostly well formed, some cut short or corrupted. Each accepted
// byte goes through a behavioral scanner that predicts the result
// transaction it causes. Results are checked in order, field by field.
// Both ports idle at random, first one way, then the other, then not at all.
// ----------------------------------------------------------------------------
module tb_top;
  import pws_pkg::*;

  localparam logic [2:0] WIRE_RSVD6 = 3'd6;
  localparam logic [2:0] WIRE_RSVD7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned DIR_ROWS = 25;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned WATCHDOG_T = 6000000;

  typedef enum logic [2:0] {SC_TAG, SC_VALUE, SC_LENGTH, SC_PAYLOAD, SC_HOLD} scan_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [31:0] field_id;
  logic [2:0]  wire_kind;
  logic [63:0] varint_value;
  logic [7:0]  payload_byte;
  logic        field_end;
  logic [2:0]  error_code;
  logic        buffer_end;

  // scanner model state
  scan_phase_t sc_phase;
  logic [63:0] sc_acc;
  logic [3:0]  sc_nbytes;
  logic [63:0] sc_left;
  logic [31:0] sc_field;
  logic [2:0]  sc_wire;
  bit          sc_held;

  result_t     pending_results[$];
  logic [7:0]  msg_bytes[$];
  stim_row_t   dir_tab[DIR_ROWS];
  int unsigned bad_count = 0;
  int unsigned live_items = 0;
  int          send_idle_pct = 24;
  int          recv_stall_pct = 76;

  protobuf_wire_field_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .field_id     (field_id),
    .wire_kind    (wire_kind),
    .varint_value (varint_value),
    .payload_byte (payload_byte),
    .field_end    (field_end),
    .error_code   (error_code),
    .buffer_end   (buffer_end)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic result_t mk_res(logic [1:0] ev, logic [31:0] fld, logic [2:0] wt,
                                     logic [63:0] val, logic [7:0] pb, logic fend,
                                     logic [2:0] code, logic bend);
    result_t r;
    r.event_res    = ev;
    r.field_id     = fld;
    r.wire_kind    = wt;
    r.varint_value = val;
    r.payload_byte = pb;
    r.field_end    = fend;
    r.error_code   = code;
    r.buffer_end   = bend;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] x;
    x = $urandom;
    return x[7:0];
  endfunction

  function automatic logic [63:0] rand64();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    return {hi, lo};
  endfunction

  // ---------------------------------------------------------------------------
  // behavioral scanner: predicts the result of one accepted byte
  // ---------------------------------------------------------------------------
  task automatic scan_clear();
    sc_phase  = SC_TAG;
    sc_acc    = '0;
    sc_nbytes = '0;
    sc_left   = '0;
    sc_field  = '0;
    sc_wire   = '0;
    sc_held   = 1'b0;
  endtask

  task automatic scan_fail(input logic [2:0] code, input logic l,
                           output bit got, output result_t r);
    r        = mk_res(EV_ERROR, sc_field, sc_wire, 64'd0, 8'h00, 1'b0, code, l);
    got      = 1'b1;
    sc_phase = SC_HOLD;
    sc_held  = 1'b1;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic l,
                           output bit got, output result_t r);
    logic [63:0] grp;
    logic [63:0] v;
    bit          done;
    bit          too_long;
    got = 1'b0;
    r   = '0;
    // error hold swallows everything up to the buffer's last byte
    if (sc_held || sc_phase == SC_HOLD) begin
      if (l) scan_clear();
      return;
    end
    if (sc_phase != SC_PAYLOAD) begin
      if (sc_phase == SC_TAG && sc_nbytes == 4'd0) begin
        sc_field = '0;
        sc_wire  = '0;
      end
      // 7-bit groups, low first; groups past bit 63 fall off
      if (sc_nbytes < VARINT_MAX_BYTES) begin
        grp       = {57'd0, b[6:0]};
        sc_acc    = sc_acc | (grp << (7 * sc_nbytes));
        sc_nbytes = sc_nbytes + 4'd1;
      end
      done     = !b[7];
      too_long = b[7] && (sc_nbytes >= VARINT_MAX_BYTES);
      if (too_long) begin
        scan_fail(ERR_TOO_LONG, l, got, r);
      end else if (!done) begin
        if (l) scan_fail(ERR_TRUNCATED, l, got, r);
      end else begin
        v         = sc_acc;
        sc_acc    = '0;
        sc_nbytes = '0;
        case (sc_phase)
          SC_TAG: begin
            sc_field = v[34:3];
            sc_wire  = v[2:0];
            case (sc_wire)
              WIRE_VARINT, WIRE_LEN: begin
                if (l) scan_fail(ERR_TRUNCATED, l, got, r);
                else if (sc_wire == WIRE_VARINT) sc_phase = SC_VALUE;
                else sc_phase = SC_LENGTH;
              end
              WIRE_FIXED64, WIRE_FIXED32: begin
                if (l) begin
                  scan_fail(ERR_PAST_END, l, got, r);
                end else begin
                  sc_left  = (sc_wire == WIRE_FIXED64) ? FIXED64_LEN : FIXED32_LEN;
                  sc_phase = SC_PAYLOAD;
                end
              end
              WIRE_SGROUP, WIRE_EGROUP: scan_fail(ERR_GROUP, l, got, r);
              default: scan_fail(ERR_WIRE, l, got, r);
            endcase
          end
          SC_VALUE: begin
            r        = mk_res(EV_VARINT, sc_field, sc_wire, v, 8'h00, 1'b1, ERR_NONE, l);
            got      = 1'b1;
            sc_phase = SC_TAG;
          end
          default: begin
            // length prefix of a length-delimited field
            if (v == 64'd0) begin
              r        = mk_res(EV_HEADER, sc_field, sc_wire, 64'd0, 8'h00, 1'b1, ERR_NONE, l);
              got      = 1'b1;
              sc_phase = SC_TAG;
            end else if (l) begin
              scan_fail(ERR_PAST_END, l, got, r);
            end else begin
              r        = mk_res(EV_HEADER, sc_field, sc_wire, v, 8'h00, 1'b0, ERR_NONE, l);
              got      = 1'b1;
              sc_left  = v;
              sc_phase = SC_PAYLOAD;
            end
          end
        endcase
      end
    end else begin
      // payload byte of a length-delimited or fixed field
      if (sc_left != 64'd0) sc_left = sc_left - 64'd1;
      if (sc_left == 64'd0) begin
        r        = mk_res(EV_PAYLOAD, sc_field, sc_wire, 64'd0, b, 1'b1, ERR_NONE, l);
        got      = 1'b1;
        sc_phase = SC_TAG;
      end else if (l) begin
        scan_fail(ERR_PAST_END, l, got, r);
      end else begin
        r   = mk_res(EV_PAYLOAD, sc_field, sc_wire, 64'd0, b, 1'b0, ERR_NONE, l);
        got = 1'b1;
      end
    end
    if (l) scan_clear();
  endtask

  // ---------------------------------------------------------------------------
  // input side: one byte per transaction, prediction at acceptance
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                           input result_t typed_res);
    bit      got;
    bit      live;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    live = !(sc_held || sc_phase == SC_HOLD);
    scan_byte(d, l, got, r);
    if (typed) pending_results.insert(pending_results.size(), typed_res);
    else if (got) pending_results.insert(pending_results.size(), r);
    if (live) live_items++;
    @(negedge clk);
  endtask

  // sender holds off until the scanner has nothing in flight
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random message builder
  // ---------------------------------------------------------------------------
  function automatic int pad_len();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // minimal encoding plus optional redundant zero groups, ten bytes at most
  task automatic add_varint(input logic [63:0] v, input int pad);
    int          n;
    int          total;
    logic [63:0] g;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 64'd0) n++;
    total = (n + pad > 10) ? 10 : n + pad;
    for (int i = 0; i < total; i++) begin
      g = v >> (7 * i);
      msg_bytes.insert(msg_bytes.size(), {(i != total - 1), g[6:0]});
    end
  endtask

  task automatic add_field(input logic [2:0] wt);
    logic [63:0] tagv;
    int          len;
    tagv      = rand64() >> $urandom_range(63);
    tagv[2:0] = wt;
    add_varint(tagv, pad_len());
    case (wt)
      WIRE_VARINT: add_varint(rand64() >> $urandom_range(63), pad_len());
      WIRE_LEN: begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        add_varint(64'(len), pad_len());
        repeat (len) msg_bytes.insert(msg_bytes.size(), rand_byte());
      end
      WIRE_FIXED64: repeat (8) msg_bytes.insert(msg_bytes.size(), rand_byte());
      WIRE_FIXED32: repeat (4) msg_bytes.insert(msg_bytes.size(), rand_byte());
      default: repeat ($urandom_range(0, 3)) msg_bytes.insert(msg_bytes.size(), rand_byte());
    endcase
  endtask

  function automatic logic [2:0] pick_good_wire();
    case ($urandom_range(3))
      0: return WIRE_VARINT;
      1: return WIRE_FIXED64;
      2: return WIRE_LEN;
      default: return WIRE_FIXED32;
    endcase
  endfunction

  function automatic logic [2:0] pick_bad_wire();
    case ($urandom_range(3))
      0: return WIRE_SGROUP;
      1: return WIRE_EGROUP;
      2: return WIRE_RSVD6;
      default: return WIRE_RSVD7;
    endcase
  endfunction

  // mostly well-formed buffers; the rest cut short, corrupted or padded with noise
  task automatic build_buffer();
    int         kind;
    int         nf;
    int         bad_at;
    int         cut;
    logic [3:0] f4;
    logic [7:0] rb;
    msg_bytes.delete();
    kind   = $urandom_range(99);
    nf     = $urandom_range(1, 4);
    bad_at = $urandom_range(0, nf - 1);
    for (int i = 0; i < nf; i++) begin
      if (kind >= 75 && kind < 85 && i == bad_at) begin
        add_field(pick_bad_wire());
      end else if (kind >= 85 && kind < 93 && i == bad_at) begin
        // overlong varint, either as a value or as the tag itself
        if ($urandom_range(1) == 1) begin
          f4 = 4'($urandom_range(15));
          msg_bytes.insert(msg_bytes.size(), {1'b0, f4, WIRE_VARINT});
        end
        repeat ($urandom_range(10, 12)) begin
          rb = rand_byte();
          msg_bytes.insert(msg_bytes.size(), {1'b1, rb[6:0]});
        end
        rb = rand_byte();
        msg_bytes.insert(msg_bytes.size(), {1'b0, rb[6:0]});
      end else begin
        add_field(pick_good_wire());
      end
    end
    if (kind >= 93) repeat ($urandom_range(1, 12)) msg_bytes.insert(msg_bytes.size(), rand_byte());
    if (kind >= 65 && kind < 75) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, in-order check of every result transaction
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic check_result(input result_t seen);
    result_t want;
    string   diff;
    diff = "";
    if (pending_results.size() == 0) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS) $display("result with nothing pending: got %h", seen);
      return;
    end
    want = pending_results.pop_front();
    if (want.event_res !== seen.event_res) diff = {diff, " event_res"};
    if (want.field_id !== seen.field_id) diff = {diff, " field_id"};
    if (want.wire_kind !== seen.wire_kind) diff = {diff, " wire_kind"};
    if (want.varint_value !== seen.varint_value) diff = {diff, " varint_value"};
    if (want.payload_byte !== seen.payload_byte) diff = {diff, " payload_byte"};
    if (want.field_end !== seen.field_end) diff = {diff, " field_end"};
    if (want.error_code !== seen.error_code) diff = {diff, " error_code"};
    if (want.buffer_end !== seen.buffer_end) diff = {diff, " buffer_end"};
    if (diff != "") begin
      bad_count++;
      if (bad_count <= MAX_REPORTS)
        $display("mismatch in%s: exp %h got %h", diff, want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_result({event_res, field_id, wire_kind, varint_value, payload_byte,
                    field_end, error_code, buffer_end});
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int stage;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    scan_clear();

    // varint field, length-delimited fields, fixed fields, then error cases
    dir_tab[0]  = '{8'h08, 1'b0, 1'b0, '0};
    dir_tab[1]  = '{8'hFF, 1'b0, 1'b0, '0};
    dir_tab[2]  = '{8'h7F, 1'b0, 1'b1,
                    mk_res(EV_VARINT, 32'd1, WIRE_VARINT, 64'h3FFF, 8'h00, 1'b1, ERR_NONE, 1'b0)};
    dir_tab[3]  = '{8'h12, 1'b0, 1'b0, '0};
    dir_tab[4]  = '{8'h02, 1'b0, 1'b1,
                    mk_res(EV_HEADER, 32'd2, WIRE_LEN, 64'd2, 8'h00, 1'b0, ERR_NONE, 1'b0)};
    dir_tab[5]  = '{8'h00, 1'b0, 1'b1,
                    mk_res(EV_PAYLOAD, 32'd2, WIRE_LEN, 64'd0, 8'h00, 1'b0, ERR_NONE, 1'b0)};
    dir_tab[6]  = '{8'hFF, 1'b0, 1'b1,
                    mk_res(EV_PAYLOAD, 32'd2, WIRE_LEN, 64'd0, 8'hFF, 1'b1, ERR_NONE, 1'b0)};
    dir_tab[7]  = '{8'h1A, 1'b0, 1'b0, '0};
    dir_tab[8]  = '{8'h00, 1'b0, 1'b1,
                    mk_res(EV_HEADER, 32'd3, WIRE_LEN, 64'd0, 8'h00, 1'b1, ERR_NONE, 1'b0)};
    dir_tab[9]  = '{8'h0D, 1'b0, 1'b0, '0};
    dir_tab[10] = '{8'h11, 1'b0, 1'b0, '0};
    dir_tab[11] = '{8'h22, 1'b0, 1'b0, '0};
    dir_tab[12] = '{8'h33, 1'b0, 1'b0, '0};
    dir_tab[13] = '{8'h44, 1'b0, 1'b0, '0};
    dir_tab[14] = '{8'h09, 1'b0, 1'b0, '0};
    dir_tab[15] = '{8'hAA, 1'b0, 1'b0, '0};
    // fixed64 cut short by the end of the buffer
    dir_tab[16] = '{8'hBB, 1'b1, 1'b1,
                    mk_res(EV_ERROR, 32'd1, WIRE_FIXED64, 64'd0, 8'h00, 1'b0, ERR_PAST_END, 1'b1)};
    dir_tab[17] = '{8'h0B, 1'b0, 1'b1,
                    mk_res(EV_ERROR, 32'd1, WIRE_SGROUP, 64'd0, 8'h00, 1'b0, ERR_GROUP, 1'b0)};
    // bytes under error hold, the last one releases it
    dir_tab[18] = '{8'h55, 1'b0, 1'b0, '0};
    dir_tab[19] = '{8'h00, 1'b1, 1'b0, '0};
    dir_tab[20] = '{8'h0E, 1'b1, 1'b1,
                    mk_res(EV_ERROR, 32'd1, WIRE_RSVD6, 64'd0, 8'h00, 1'b0, ERR_WIRE, 1'b1)};
    dir_tab[21] = '{8'h80, 1'b1, 1'b1,
                    mk_res(EV_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'h00, 1'b0, ERR_TRUNCATED, 1'b1)};
    dir_tab[22] = '{8'h0C, 1'b0, 1'b1,
                    mk_res(EV_ERROR, 32'd1, WIRE_EGROUP, 64'd0, 8'h00, 1'b0, ERR_GROUP, 1'b0)};
    dir_tab[23] = '{8'hFF, 1'b1, 1'b0, '0};
    // varint tag with nothing after it
    dir_tab[24] = '{8'h00, 1'b1, 1'b1,
                    mk_res(EV_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'h00, 1'b0, ERR_TRUNCATED, 1'b1)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);

    // random messages in three idle regimes
    live_items = 0;
    stage      = 0;
    while (live_items < RANDOM_ITEMS) begin
      if (stage == 0 && live_items >= RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct  = 76;
        recv_stall_pct = 24;
        stage          = 1;
      end else if (stage == 1 && live_items >= 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stage          = 2;
      end
      build_buffer();
      for (int i = 0; i < msg_bytes.size(); i++)
        send_byte(msg_bytes[i], (i == msg_bytes.size() - 1), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // let the pipeline empty, then watch a little longer for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(WATCHDOG_T);
    $display("status: fail");
    $finish;
  end

endmodule
